// ===== design/stfm_pkg.sv =====
// ----------------------------------------------------------------------------
// stfm_pkg
// Shared types, register indexes and the sine table generator of the mixer.
// ----------------------------------------------------------------------------
package stfm_pkg;

	localparam int CFG_INDEX_WIDTH = 3;

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PHASE_STEP     = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_AMPLITUDE      = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_TONE_LENGTH    = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FADE_LENGTH    = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FADE_GAIN_STEP = 3'd4;

	localparam int CFG_DATA_WIDTH = 32;
	localparam int LENGTH_WIDTH   = 24;
	localparam int GAIN_WIDTH     = 17;
	localparam int SINE_WIDTH     = 16;

	localparam logic [GAIN_WIDTH-1:0] GAIN_ONE  = 17'h10000;
	localparam logic [16:0]           AMP_FULL  = 17'h08000;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = 2;

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef struct packed {
		logic [31:0]             phase_step;
		logic [15:0]             amplitude;
		logic [LENGTH_WIDTH-1:0] tone_length;
		logic [15:0]             fade_length;
		logic [15:0]             fade_gain_step;
	} cfg_t;

	// one table entry, quarter-wave folded odd series through x^13, Q1.15
	function automatic logic signed [SINE_WIDTH-1:0] sine_entry(
		input logic [31:0] k,
		input int unsigned log2_depth
	);
		logic [63:0] depth;
		logic [63:0] four;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] sum;
		logic [63:0] mag;
		depth = 64'd1 << log2_depth;
		four  = {32'd0, k} << 2;
		q     = four >> log2_depth;
		r     = four & (depth - 64'd1);
		if (q[0]) begin
			r = depth - r;
		end
		x   = (HALF_PI_Q30 * r) >> log2_depth;
		x2  = (x * x) >> 30;
		sum = x;
		t   = ((x * x2) >> 30) / 64'd6;
		sum = sum - t;
		t   = ((t * x2) >> 30) / 64'd20;
		sum = sum + t;
		t   = ((t * x2) >> 30) / 64'd42;
		sum = sum - t;
		t   = ((t * x2) >> 30) / 64'd72;
		sum = sum + t;
		t   = ((t * x2) >> 30) / 64'd110;
		sum = sum - t;
		t   = ((t * x2) >> 30) / 64'd156;
		sum = sum + t;
		mag = (sum + 64'd16384) >> 15;
		if (mag > 64'd32767) begin
			mag = 64'd32767;
		end
		sine_entry = q[1] ? -mag[SINE_WIDTH-1:0] : mag[SINE_WIDTH-1:0];
	endfunction

endpackage

// ===== design/stfm_front.sv =====
// ----------------------------------------------------------------------------
// stfm_front
// Accepts input samples, keeps phase and sample count, classifies each sample
// as inside or outside the tone and hands it to the queue.
// ----------------------------------------------------------------------------
module stfm_front #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COUNT_WIDTH  = 24,
	parameter int INDEX_WIDTH  = 10,
	parameter int ENTRY_WIDTH  = SAMPLE_WIDTH + 1 + INDEX_WIDTH + COUNT_WIDTH + 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  stfm_pkg::cfg_t          cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [SAMPLE_WIDTH-1:0] in_mix,
	input  logic                    in_restart,
	output logic                    push_valid,
	input  logic                    push_ready,
	output logic [ENTRY_WIDTH-1:0]  push_entry
);

	localparam int LW = (COUNT_WIDTH > stfm_pkg::LENGTH_WIDTH) ?
		COUNT_WIDTH : stfm_pkg::LENGTH_WIDTH;

	logic [31:0]             phase_acc_q;
	logic [COUNT_WIDTH-1:0]  sample_index_q;
	logic [31:0]             phase_eff;
	logic [COUNT_WIDTH-1:0]  index_eff;
	logic [LW-1:0]           index_ext;
	logic [LW-1:0]           length_ext;
	logic [LW-1:0]           remain;
	logic                    active;
	logic                    accept;
	logic [INDEX_WIDTH-1:0]  table_index;

	assign accept     = in_valid && push_ready;
	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	// restart clears phase and count before this sample is looked at
	assign phase_eff  = in_restart ? 32'd0 : phase_acc_q;
	assign index_eff  = in_restart ? '0 : sample_index_q;
	assign index_ext  = LW'(index_eff);
	assign length_ext = LW'(cfg.tone_length);
	assign active     = index_ext < length_ext;
	// samples left before the end of the tone, meaningful only when active
	assign remain      = length_ext - LW'(1) - index_ext;
	assign table_index = phase_eff[31 -: INDEX_WIDTH];

	assign push_entry = {remain[stfm_pkg::LENGTH_WIDTH-1:0], index_eff, table_index,
		active, in_mix};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q    <= '0;
			sample_index_q <= '0;
		end else if (accept) begin
			if (active) begin
				phase_acc_q    <= phase_eff + cfg.phase_step;
				sample_index_q <= index_eff + COUNT_WIDTH'(1);
			end else begin
				phase_acc_q    <= phase_eff;
				sample_index_q <= index_eff;
			end
		end
	end

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_restart && active) |=>
		(sample_index_q == $past(sample_index_q) + COUNT_WIDTH'(1)))
		else $error("sample count did not advance on an active sample");

endmodule

// ===== design/stfm_queue.sv =====
// ----------------------------------------------------------------------------
// stfm_queue
// Short register queue between the front and the back of the mixer.
// ----------------------------------------------------------------------------
module stfm_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_entry,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_entry
);

	localparam int PW = stfm_pkg::QUEUE_PTR_W;
	localparam int CW = PW + 1;

	logic [WIDTH-1:0] slot_q [stfm_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = count_q != CW'(stfm_pkg::QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_entry  = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(stfm_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("queue count missed a push");

endmodule

// ===== design/stfm_back.sv =====
// ----------------------------------------------------------------------------
// stfm_back
// Pipeline that looks up the sine, forms the fade gain, scales the tone,
// adds it to samples inside the tone and saturates, ending in the output register.
// ----------------------------------------------------------------------------
module stfm_back #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COUNT_WIDTH  = 24,
	parameter int INDEX_WIDTH  = 10,
	parameter int TABLE_DEPTH  = 1024,
	parameter int ENTRY_WIDTH  = SAMPLE_WIDTH + 1 + INDEX_WIDTH + COUNT_WIDTH + 24
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  stfm_pkg::cfg_t          cfg,
	input  logic                    pop_valid,
	output logic                    pop_ready,
	input  logic [ENTRY_WIDTH-1:0]  pop_entry,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [SAMPLE_WIDTH-1:0] out_mix,
	output logic                    out_saturated,
	output logic                    out_active
);

	localparam int GW    = stfm_pkg::GAIN_WIDTH;
	localparam int SNW   = stfm_pkg::SINE_WIDTH;
	localparam int SHIFT = 47 - SAMPLE_WIDTH;
	localparam int TW    = SAMPLE_WIDTH + 1;
	localparam int XW    = SAMPLE_WIDTH + 2;
	localparam int O_ACT = SAMPLE_WIDTH;
	localparam int O_IDX = O_ACT + 1;
	localparam int O_N   = O_IDX + INDEX_WIDTH;
	localparam int O_M   = O_N + COUNT_WIDTH;

	logic signed [SNW-1:0] sine_rom [TABLE_DEPTH];

	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_rom
		assign sine_rom[k] = stfm_pkg::sine_entry(32'(k), $clog2(TABLE_DEPTH));
	end

	logic                            enable;
	logic [SAMPLE_WIDTH-1:0]         e_mix;
	logic                            e_active;
	logic [INDEX_WIDTH-1:0]          e_idx;
	logic [COUNT_WIDTH-1:0]          e_n;
	logic [stfm_pkg::LENGTH_WIDTH-1:0] e_m;
	logic [31:0]                     in_prod;
	logic [31:0]                     out_prod;
	logic [GW-1:0]                   gin;
	logic [GW-1:0]                   gout;

	logic                    v_s1, v_s2, v_s3, v_s4;
	logic                    out_valid_q;
	logic [SAMPLE_WIDTH-1:0] mix_s1, mix_s2, mix_s3, mix_s4;
	logic                    act_s1, act_s2, act_s3, act_s4;
	logic signed [SNW-1:0]   sine_s1, sine_s2, sine_s3;
	logic [GW-1:0]           gin_s1, gout_s1;
	logic [GW-1:0]           gain_s2;
	logic [31:0]             ampgain_s3;
	logic signed [47:0]      prod_s4;
	logic [SAMPLE_WIDTH-1:0] mix_out_q;
	logic                    sat_q;
	logic                    act_q;

	logic [2*GW:0]           gain_full;
	logic [16:0]             amp_cap;
	logic [2*GW-1:0]         ampgain_full;
	logic signed [48:0]      prod_full;
	logic signed [47:0]      rounded;
	logic signed [TW-1:0]    tone;
	logic signed [XW-1:0]    sum;
	logic signed [XW-1:0]    hi_lim;
	logic signed [XW-1:0]    lo_lim;

	assign enable    = !out_valid_q || out_ready;
	assign pop_ready = enable;

	assign e_mix    = pop_entry[SAMPLE_WIDTH-1:0];
	assign e_active = pop_entry[O_ACT];
	assign e_idx    = pop_entry[O_N-1:O_IDX];
	assign e_n      = pop_entry[O_M-1:O_N];
	assign e_m      = pop_entry[ENTRY_WIDTH-1:O_M];

	// ramp gains, capped at one
	assign in_prod  = 32'(e_n[15:0]) * 32'(cfg.fade_gain_step);
	assign out_prod = 32'(e_m[15:0]) * 32'(cfg.fade_gain_step);
	assign gin  = (32'(e_n) >= 32'(cfg.fade_length) || in_prod > 32'(stfm_pkg::GAIN_ONE)) ?
		stfm_pkg::GAIN_ONE : in_prod[GW-1:0];
	assign gout = (32'(e_m) >= 32'(cfg.fade_length) || out_prod > 32'(stfm_pkg::GAIN_ONE)) ?
		stfm_pkg::GAIN_ONE : out_prod[GW-1:0];

	assign gain_full    = (2*GW+1)'(gin_s1) * (2*GW+1)'(gout_s1) + (2*GW+1)'(32768);
	assign amp_cap      = (cfg.amplitude > stfm_pkg::AMP_FULL[15:0]) ?
		stfm_pkg::AMP_FULL : {1'b0, cfg.amplitude};
	assign ampgain_full = (2*GW)'(amp_cap) * (2*GW)'(gain_s2);
	assign prod_full    = 49'(sine_s3) * $signed({17'd0, ampgain_s3});

	// round half up to the sample's fraction bits
	assign rounded = prod_s4 + (48'sd1 <<< (SHIFT - 1));
	assign tone    = TW'(rounded >>> SHIFT);
	assign sum     = XW'($signed(mix_s4)) + XW'(tone);
	assign hi_lim  = (XW'(1) <<< (SAMPLE_WIDTH - 1)) - XW'(1);
	assign lo_lim  = -(XW'(1) <<< (SAMPLE_WIDTH - 1));

	always_ff @(posedge clk) begin
		if (enable) begin
			sine_s1 <= sine_rom[e_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (enable) begin
			mix_s1     <= e_mix;
			act_s1     <= e_active;
			gin_s1     <= gin;
			gout_s1    <= gout;
			mix_s2     <= mix_s1;
			act_s2     <= act_s1;
			sine_s2    <= sine_s1;
			gain_s2    <= gain_full[GW+15:16];
			mix_s3     <= mix_s2;
			act_s3     <= act_s2;
			sine_s3    <= sine_s2;
			ampgain_s3 <= ampgain_full[31:0];
			mix_s4     <= mix_s3;
			act_s4     <= act_s3;
			prod_s4    <= prod_full[47:0];
			act_q      <= act_s4;
			if (!act_s4) begin
				mix_out_q <= mix_s4;
				sat_q     <= 1'b0;
			end else if (sum > hi_lim) begin
				mix_out_q <= hi_lim[SAMPLE_WIDTH-1:0];
				sat_q     <= 1'b1;
			end else if (sum < lo_lim) begin
				mix_out_q <= lo_lim[SAMPLE_WIDTH-1:0];
				sat_q     <= 1'b1;
			end else begin
				mix_out_q <= sum[SAMPLE_WIDTH-1:0];
				sat_q     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (enable) begin
			v_s1        <= pop_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			out_valid_q <= v_s4;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_mix       = mix_out_q;
	assign out_saturated = sat_q;
	assign out_active    = act_q;

	a_last_stage_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && enable) |=> out_valid_q)
		else $error("sample lost between last stage and output register");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !enable) |=> v_s1)
		else $error("pipeline moved while stalled");

endmodule

// ===== design/sine_tone_fade_mixer_unit.sv =====
// ----------------------------------------------------------------------------
// sine_tone_fade_mixer_unit
// Adds a faded sine tone from a phase accumulator to a sample stream.
// ----------------------------------------------------------------------------
// Samples enter on the s_axis channel: tdata carries mix_in, tuser[0] is the
// restart flag that marks the first sample of a tone. Results leave on the
// m_axis channel: tdata carries mix_out, tuser holds saturated and tone_active.
// Five registers on the cfg channel (phase step, amplitude, tone length, fade
// length, fade gain step) are to be written only while the stream is idle,
// which the block does not enforce; cfg_ready is always high and unknown
// indexes are dropped. Throughput is one sample per cycle while the queue has
// room: the phase and count updates are single adds in the front. A result
// goes through the four-entry queue, the registered sine table read, the
// gain, amplitude and tone multiplier stages and the output register.
// When the receiver stalls the back pipeline freezes and the queue absorbs up
// to four samples before s_axis_tready falls. Reset clears the registers, the
// phase, the sample count, the queue and all valid flags.
// ----------------------------------------------------------------------------
module sine_tone_fade_mixer_unit #(
	parameter int SINE_TABLE_DEPTH = 1024,
	parameter int SAMPLE_WIDTH     = 16,
	parameter int COUNT_WIDTH      = 24
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,  // mix_in
	input  logic                                    s_axis_tuser,  // restart
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       m_axis_tdata,  // mix_out
	output logic [1:0]                              m_axis_tuser,  // saturated, tone_active
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [stfm_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  logic [stfm_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

	localparam int DW          = ((SAMPLE_WIDTH + 7) / 8) * 8;
	localparam int INDEX_WIDTH = $clog2(SINE_TABLE_DEPTH);
	localparam int ENTRY_WIDTH = SAMPLE_WIDTH + 1 + INDEX_WIDTH + COUNT_WIDTH +
		stfm_pkg::LENGTH_WIDTH;

	stfm_pkg::cfg_t cfg_q;

	logic                    push_valid;
	logic                    push_ready;
	logic [ENTRY_WIDTH-1:0]  push_entry;
	logic                    pop_valid;
	logic                    pop_ready;
	logic [ENTRY_WIDTH-1:0]  pop_entry;
	logic [SAMPLE_WIDTH-1:0] out_mix;
	logic                    out_saturated;
	logic                    out_active;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				stfm_pkg::CFG_PHASE_STEP:     cfg_q.phase_step     <= cfg_data;
				stfm_pkg::CFG_AMPLITUDE:      cfg_q.amplitude      <= cfg_data[15:0];
				stfm_pkg::CFG_TONE_LENGTH:    cfg_q.tone_length    <=
					cfg_data[stfm_pkg::LENGTH_WIDTH-1:0];
				stfm_pkg::CFG_FADE_LENGTH:    cfg_q.fade_length    <= cfg_data[15:0];
				stfm_pkg::CFG_FADE_GAIN_STEP: cfg_q.fade_gain_step <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	stfm_front #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH),
		.INDEX_WIDTH  (INDEX_WIDTH),
		.ENTRY_WIDTH  (ENTRY_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_mix     (s_axis_tdata[SAMPLE_WIDTH-1:0]),
		.in_restart (s_axis_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	stfm_queue #(
		.WIDTH (ENTRY_WIDTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	stfm_back #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH),
		.INDEX_WIDTH  (INDEX_WIDTH),
		.TABLE_DEPTH  (SINE_TABLE_DEPTH),
		.ENTRY_WIDTH  (ENTRY_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.pop_entry     (pop_entry),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_mix       (out_mix),
		.out_saturated (out_saturated),
		.out_active    (out_active)
	);

	assign m_axis_tdata = DW'(out_mix);
	assign m_axis_tuser = {out_active, out_saturated};

endmodule
